>>> hdl/lfu_pkg.sv
// Package for the LFU cache table: sizes, payload structs, entry layout, FSM states.
// Depends on nothing; used by lfu_cache_table.
package lfu_pkg;

   localparam int CAPACITY  = 16;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = IDX_W + 1;
   localparam int RANK_W    = IDX_W;
   localparam int THR_W     = RANK_W + 1;
   localparam int OCC_W     = $clog2(CAPACITY + 1);
   localparam int CAP_W     = 5;
   localparam int ECAP_W    = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int CAP_RESET = (CAPACITY > 31) ? 31 : CAPACITY;
   localparam int USE_W     = 16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] lookup_key;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic [USE_W-1:0]   use_count;
      logic [RANK_W-1:0]  rank;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

>>> hdl/lfu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lfu_cache_table.sv
// Top level of the LFU cache table (LRU tie-break); entries live in lfu_ram.
// Depends on lfu_pkg and lfu_ram.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | lfu_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | lfu_pkg::rsp_type
//   csr     | in        | csr_wr_en           | capacity_in_use, 5 bits
//
// One transaction at a time: a scan pass over all CAPACITY entries, a decide state,
// then a read-modify-write pass over all entries when the entry table changes:
// puts and hits take both passes, get misses only the scan pass.
// The single read port of the entry RAM sets the length of each pass.
// Synchronous reset clears valid bits, occupancy and control; capacity resets to CAPACITY.
// The next request is taken while a response still waits on rsp_stall.
module lfu_cache_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lfu_pkg::req_type      req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lfu_pkg::rsp_type      rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [lfu_pkg::CAP_W-1:0] csr_wr_data
);

   lfu_pkg::state_type state_ff, state_in;
   lfu_pkg::req_type   req_ff, req_in;
   lfu_pkg::rsp_type   rsp_ff, rsp_in, res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [lfu_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic [lfu_pkg::OCC_W-1:0]    occ_ff, occ_in;
   logic [lfu_pkg::CAPACITY-1:0] valid_ff, valid_in;

   logic [lfu_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      pend_ff, pend_in;
   logic [lfu_pkg::IDX_W-1:0] pend_idx_ff, pend_idx_in;

   logic                       hit_found_ff, hit_found_in;
   logic [lfu_pkg::IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   lfu_pkg::entry_type         hit_ent_ff, hit_ent_in;
   logic                       vic_found_ff, vic_found_in;
   logic [lfu_pkg::IDX_W-1:0]  vic_idx_ff, vic_idx_in;
   lfu_pkg::entry_type         vic_ent_ff, vic_ent_in;
   logic                       free_found_ff, free_found_in;
   logic [lfu_pkg::IDX_W-1:0]  free_idx_ff, free_idx_in;

   logic [lfu_pkg::IDX_W-1:0]  tgt_idx_ff, tgt_idx_in;
   logic [lfu_pkg::THR_W-1:0]  thr_ff, thr_in;
   lfu_pkg::entry_type         new_ent_ff, new_ent_in;

   logic                       ram_we, ram_re;
   logic [lfu_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
   lfu_pkg::entry_type         ram_wdata, ram_rdata;

   logic [lfu_pkg::ECAP_W-1:0] ecap;

   lfu_ram #(
      .WIDTH($bits(lfu_pkg::entry_type)),
      .DEPTH(lfu_pkg::CAPACITY)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign ecap = (lfu_pkg::ECAP_W'(cap_ff) > lfu_pkg::ECAP_W'(lfu_pkg::CAPACITY)) ?
                 lfu_pkg::ECAP_W'(lfu_pkg::CAPACITY) : lfu_pkg::ECAP_W'(cap_ff);

   assign req_stall   = (state_ff != lfu_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
         occ_ff       <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
      end
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      res_ff        <= res_in;
      pend_idx_ff   <= pend_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_ent_ff    <= hit_ent_in;
      vic_found_ff  <= vic_found_in;
      vic_idx_ff    <= vic_idx_in;
      vic_ent_ff    <= vic_ent_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      tgt_idx_ff    <= tgt_idx_in;
      thr_ff        <= thr_in;
      new_ent_ff    <= new_ent_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      occ_in        = occ_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      pend_idx_in   = cnt_ff[lfu_pkg::IDX_W-1:0];
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_ent_in    = hit_ent_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_ent_in    = vic_ent_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      tgt_idx_in    = tgt_idx_ff;
      thr_in        = thr_ff;
      new_ent_in    = new_ent_ff;
      ram_re        = 1'b0;
      ram_raddr     = cnt_ff[lfu_pkg::IDX_W-1:0];
      ram_we        = 1'b0;
      ram_waddr     = pend_idx_ff;
      ram_wdata     = ram_rdata;

      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               cnt_in        = '0;
               hit_found_in  = 1'b0;
               vic_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = lfu_pkg::ST_SCAN;
            end
         end
         lfu_pkg::ST_SCAN: begin
            if (cnt_ff != lfu_pkg::CNT_W'(lfu_pkg::CAPACITY)) begin
               ram_re  = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               if (valid_ff[pend_idx_ff]) begin
                  if (ram_rdata.key == req_ff.lookup_key) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = pend_idx_ff;
                     hit_ent_in   = ram_rdata;
                  end
                  if (!vic_found_ff || (ram_rdata.use_count < vic_ent_ff.use_count) ||
                      ((ram_rdata.use_count == vic_ent_ff.use_count) &&
                       (ram_rdata.rank > vic_ent_ff.rank))) begin
                     vic_found_in = 1'b1;
                     vic_idx_in   = pend_idx_ff;
                     vic_ent_in   = ram_rdata;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = pend_idx_ff;
               end
            end else if (cnt_ff == lfu_pkg::CNT_W'(lfu_pkg::CAPACITY)) begin
               state_in = lfu_pkg::ST_DECIDE;
            end
         end
         lfu_pkg::ST_DECIDE: begin
            res_in.hit         = 1'b0;
            res_in.read_value  = '1;
            res_in.evicted     = 1'b0;
            res_in.evicted_key = '0;
            cnt_in             = '0;
            state_in           = lfu_pkg::ST_FINISH;
            if (ecap != '0) begin
               if (hit_found_ff) begin
                  res_in.hit = 1'b1;
                  new_ent_in = hit_ent_ff;
                  if (req_ff.opcode == lfu_pkg::OP_GET) begin
                     res_in.read_value = hit_ent_ff.value;
                  end else begin
                     new_ent_in.value = req_ff.write_value;
                  end
                  if (hit_ent_ff.use_count != '1) begin
                     new_ent_in.use_count = hit_ent_ff.use_count + 1'b1;
                  end
                  new_ent_in.rank = '0;
                  tgt_idx_in      = hit_idx_ff;
                  thr_in          = lfu_pkg::THR_W'(hit_ent_ff.rank);
                  state_in        = lfu_pkg::ST_UPDATE;
               end else if (req_ff.opcode == lfu_pkg::OP_PUT) begin
                  new_ent_in.key       = req_ff.lookup_key;
                  new_ent_in.value     = req_ff.write_value;
                  new_ent_in.use_count = lfu_pkg::USE_W'(1);
                  new_ent_in.rank      = '0;
                  if ((lfu_pkg::ECAP_W'(occ_ff) >= ecap) && vic_found_ff) begin
                     res_in.evicted     = 1'b1;
                     res_in.evicted_key = vic_ent_ff.key;
                     tgt_idx_in         = vic_idx_ff;
                     thr_in             = lfu_pkg::THR_W'(vic_ent_ff.rank);
                     state_in           = lfu_pkg::ST_UPDATE;
                  end else if (free_found_ff) begin
                     tgt_idx_in           = free_idx_ff;
                     thr_in               = {1'b1, {lfu_pkg::RANK_W{1'b0}}};
                     valid_in[free_idx_ff] = 1'b1;
                     occ_in               = occ_ff + 1'b1;
                     state_in             = lfu_pkg::ST_UPDATE;
                  end
               end
            end
         end
         lfu_pkg::ST_UPDATE: begin
            if (cnt_ff != lfu_pkg::CNT_W'(lfu_pkg::CAPACITY)) begin
               ram_re  = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (pend_ff) begin
               ram_we = 1'b1;
               if (pend_idx_ff == tgt_idx_ff) begin
                  ram_wdata = new_ent_ff;
               end else if (valid_ff[pend_idx_ff] &&
                            (lfu_pkg::THR_W'(ram_rdata.rank) < thr_ff)) begin
                  ram_wdata.rank = ram_rdata.rank + 1'b1;
               end
            end else if (cnt_ff == lfu_pkg::CNT_W'(lfu_pkg::CAPACITY)) begin
               state_in = lfu_pkg::ST_FINISH;
            end
         end
         lfu_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase
   end

   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(occ_ff))
      else $error("occupancy out of step with valid bits");

   a_write_only_in_update: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == lfu_pkg::ST_UPDATE))
      else $error("entry RAM written outside update pass");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.hit && rsp_ff.evicted))
      else $error("response both hit and evicted");

   a_rsp_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && rsp_valid_in) |-> (state_ff == lfu_pkg::ST_FINISH))
      else $error("response loaded outside finish");

endmodule
